// ===== hw/rtl/rmc_pkg.sv =====
package rmc_pkg;

  // Default build of the block
  localparam int SINE_TABLE_BITS = 10;
  localparam int FRACTION_BITS   = 16;

  // pi/2 in unsigned Q2.62
  localparam logic [63:0] PI_HALF_Q62 = 64'h6487ED5110B4611A;

  // Rotation axis codes; the last code leaves the running matrix as it is
  typedef enum logic [1:0] {
    AXIS_X    = 2'd0,
    AXIS_Y    = 2'd1,
    AXIS_Z    = 2'd2,
    AXIS_NONE = 2'd3
  } axis_t;

  // Unsigned Q2.62 product, both operands below 2^63
  function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // Restoring long division, used only while building the sine table
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // sin(pi/2 * k / 2^tbits) by Taylor series in Q2.62, rounded to fbits
  // fraction bits and capped at one
  function automatic logic [63:0] sine_entry(input int unsigned k, input int unsigned tbits,
                                             input int unsigned fbits);
    logic [127:0] prod;
    logic [63:0]  x;
    logic [63:0]  x2;
    logic [63:0]  term;
    logic [63:0]  sum;
    logic [63:0]  dv;
    logic [63:0]  entry;
    logic         sub;
    prod = {64'd0, PI_HALF_Q62} * 128'(k);
    prod = prod >> tbits;
    x    = prod[63:0];
    x2   = q62_mul(x, x);
    term = x;
    sum  = x;
    dv   = 64'd1;
    sub  = 1'b1;
    while (term != 64'd0) begin
      term = udiv64(q62_mul(term, x2), (dv + 64'd1) * (dv + 64'd2));
      dv   = dv + 64'd2;
      if (sub) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
      sub = !sub;
    end
    entry = (sum + (64'd1 << (61 - fbits))) >> (62 - fbits);
    if (entry > (64'd1 << fbits)) begin
      entry = 64'd1 << fbits;
    end
    return entry;
  endfunction

endpackage

// ===== hw/rtl/rmc_sine_rom.sv =====
module rmc_sine_rom #(
  parameter int SINE_TABLE_BITS = rmc_pkg::SINE_TABLE_BITS,
  parameter int FRACTION_BITS   = rmc_pkg::FRACTION_BITS,
  localparam int AddrW  = SINE_TABLE_BITS + 1,
  localparam int EntryW = FRACTION_BITS + 1
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [AddrW-1:0]  addr_a,
  input  logic [AddrW-1:0]  addr_b,
  output logic [EntryW-1:0] data_a,
  output logic [EntryW-1:0] data_b
);

  localparam int Depth = (1 << SINE_TABLE_BITS) + 1;

  logic [EntryW-1:0] rom_data [Depth];

  // Quarter-wave table, one entry past the quarter so both ends are stored
  for (genvar k = 0; k < Depth; k++) begin : g_entry
    localparam logic [63:0] Full = rmc_pkg::sine_entry(k, SINE_TABLE_BITS, FRACTION_BITS);
    assign rom_data[k] = Full[EntryW-1:0];
  end

  // Two registered read ports
  always_ff @(posedge clk) begin
    if (rd_en) begin
      data_a <= rom_data[addr_a];
      data_b <= rom_data[addr_b];
    end
  end

endmodule

// ===== hw/rtl/rmc_row_rotate.sv =====
module rmc_row_rotate #(
  parameter int FRACTION_BITS = rmc_pkg::FRACTION_BITS,
  localparam int EntryW = FRACTION_BITS + 2
) (
  input  rmc_pkg::axis_t            axis,
  input  logic signed [EntryW-1:0]  cos_val,
  input  logic signed [EntryW-1:0]  sin_val,
  input  logic signed [EntryW-1:0]  row_in  [3],
  output logic signed [EntryW-1:0]  row_out [3]
);

  localparam int ProdW = 2 * EntryW;
  localparam int SumW  = 2 * EntryW + 2;

  localparam logic signed [SumW-1:0] Half =
    {{(SumW-1){1'b0}}, 1'b1} << (FRACTION_BITS - 1);
  localparam logic signed [SumW-1:0] MaxVal =
    {{(SumW-EntryW+1){1'b0}}, {(EntryW-1){1'b1}}};
  localparam logic signed [SumW-1:0] MinVal =
    {{(SumW-EntryW+1){1'b1}}, {(EntryW-1){1'b0}}};

  // Round to nearest (ties up), drop the fraction, clamp to the entry range
  function automatic logic signed [EntryW-1:0] round_sat(input logic signed [SumW-1:0] v);
    logic signed [SumW-1:0] r;
    r = (v + Half) >>> FRACTION_BITS;
    if (r > MaxVal) begin
      return MaxVal[EntryW-1:0];
    end else if (r < MinVal) begin
      return MinVal[EntryW-1:0];
    end
    return r[EntryW-1:0];
  endfunction

  logic [1:0]               col_a;
  logic [1:0]               col_b;
  logic                     rotate;
  logic signed [EntryW-1:0] sin_eff;
  logic signed [EntryW-1:0] ra;
  logic signed [EntryW-1:0] rb;
  logic signed [ProdW-1:0]  p_ac;
  logic signed [ProdW-1:0]  p_bs;
  logic signed [ProdW-1:0]  p_as;
  logic signed [ProdW-1:0]  p_bc;
  logic signed [SumW-1:0]   sum_a;
  logic signed [SumW-1:0]   sum_b;
  logic signed [EntryW-1:0] new_a;
  logic signed [EntryW-1:0] new_b;

  // The two columns a rotation touches; y runs with the sine negated
  always_comb begin
    rotate = 1'b1;
    col_a  = 2'd0;
    col_b  = 2'd1;
    case (axis)
      rmc_pkg::AXIS_X: begin
        col_a = 2'd1;
        col_b = 2'd2;
      end
      rmc_pkg::AXIS_Y: begin
        col_a = 2'd0;
        col_b = 2'd2;
      end
      rmc_pkg::AXIS_Z: begin
        col_a = 2'd0;
        col_b = 2'd1;
      end
      default: begin
        rotate = 1'b0;
      end
    endcase
  end

  assign sin_eff = (axis == rmc_pkg::AXIS_Y) ? -sin_val : sin_val;
  assign ra      = row_in[col_a];
  assign rb      = row_in[col_b];

  // Four products per row
  assign p_ac = ra * cos_val;
  assign p_bs = rb * sin_eff;
  assign p_as = ra * sin_eff;
  assign p_bc = rb * cos_val;

  assign sum_a = SumW'(p_ac) + SumW'(p_bs);
  assign sum_b = SumW'(p_bc) - SumW'(p_as);
  assign new_a = round_sat(sum_a);
  assign new_b = round_sat(sum_b);

  // The untouched column, and every column when there is no rotation, passes through unchanged
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (rotate && (2'(j) == col_a)) begin
        row_out[j] = new_a;
      end else if (rotate && (2'(j) == col_b)) begin
        row_out[j] = new_b;
      end else begin
        row_out[j] = row_in[j];
      end
    end
  end

endmodule

// ===== hw/rtl/rotation_matrix_composer.sv =====
// Rotation matrix composer.
// Input channel (in_valid / in_stall): one word per rotation, carrying the
// axis code, a 16-bit binary angle (full range is -pi up to pi) and a
// restart flag that resets the running matrix to identity first.
// Output channel (out_valid / out_stall): the nine entries m00..m22 of the
// running matrix after that rotation, signed with FRACTION_BITS fraction
// bits.
// A word accepted is registered in the ROM stage, then in the output register.
// Throughput: one word per cycle while the output is not stalled, set by the
// sine ROM read stage followed by one stage of twelve multipliers and rounding.
// The running matrix and the output register are the same flops, so each
// word uses the matrix left by the word before it.
// Reset (rst, synchronous) empties both stages and loads the identity.
// When the receiver stalls, the output word holds; one more word still
// enters the ROM stage, and in_stall rises only when both stages are full.
module rotation_matrix_composer #(
  parameter int SINE_TABLE_BITS = rmc_pkg::SINE_TABLE_BITS,
  parameter int FRACTION_BITS   = rmc_pkg::FRACTION_BITS,
  localparam int EntryW = FRACTION_BITS + 2
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               axis,
  input  logic signed [15:0]       angle,
  input  logic                     restart,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [EntryW-1:0] m00,
  output logic signed [EntryW-1:0] m01,
  output logic signed [EntryW-1:0] m02,
  output logic signed [EntryW-1:0] m10,
  output logic signed [EntryW-1:0] m11,
  output logic signed [EntryW-1:0] m12,
  output logic signed [EntryW-1:0] m20,
  output logic signed [EntryW-1:0] m21,
  output logic signed [EntryW-1:0] m22
);

  localparam int AddrW   = SINE_TABLE_BITS + 1;
  localparam int RomW    = FRACTION_BITS + 1;
  localparam int Quarter = 1 << SINE_TABLE_BITS;
  localparam logic signed [EntryW-1:0] One =
    {{(EntryW-FRACTION_BITS-1){1'b0}}, 1'b1, {FRACTION_BITS{1'b0}}};

  logic                     b_valid;
  rmc_pkg::axis_t           b_axis;
  logic [1:0]               b_quad;
  logic                     b_restart;
  logic                     b_en;
  logic                     out_en;
  logic [SINE_TABLE_BITS-1:0] idx;
  logic [AddrW-1:0]         addr_a;
  logic [AddrW-1:0]         addr_b;
  logic [RomW-1:0]          rom_a;
  logic [RomW-1:0]          rom_b;
  logic [RomW-1:0]          mag_s;
  logic [RomW-1:0]          mag_c;
  logic signed [EntryW-1:0] sin_val;
  logic signed [EntryW-1:0] cos_val;
  logic signed [EntryW-1:0] matrix      [3][3];
  logic signed [EntryW-1:0] base        [3][3];
  logic signed [EntryW-1:0] matrix_next [3][3];

  // Stage enables: each stage moves when it is empty or the next one moves
  assign out_en   = !out_valid || !out_stall;
  assign b_en     = !b_valid || out_en;
  assign in_stall = !b_en;

  // ROM addresses: phase index and its mirror within the quarter wave
  assign idx    = angle[13 -: SINE_TABLE_BITS];
  assign addr_a = {1'b0, idx};
  assign addr_b = AddrW'(Quarter) - {1'b0, idx};

  rmc_sine_rom #(
    .SINE_TABLE_BITS (SINE_TABLE_BITS),
    .FRACTION_BITS   (FRACTION_BITS)
  ) u_sine_rom (
    .clk    (clk),
    .rd_en  (b_en),
    .addr_a (addr_a),
    .addr_b (addr_b),
    .data_a (rom_a),
    .data_b (rom_b)
  );

  // ROM stage side registers
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_en) begin
      b_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_en) begin
      b_axis    <= rmc_pkg::axis_t'(axis);
      b_quad    <= angle[15:14];
      b_restart <= restart;
    end
  end

  // Quadrant folding; cosine is the sine one quadrant on
  always_comb begin
    mag_s   = b_quad[0] ? rom_b : rom_a;
    mag_c   = b_quad[0] ? rom_a : rom_b;
    sin_val = b_quad[1] ? -$signed({1'b0, mag_s}) : $signed({1'b0, mag_s});
    cos_val = (b_quad[1] ^ b_quad[0]) ? -$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});
  end

  // Starting matrix for this word
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (b_restart) begin
          base[i][j] = (i == j) ? One : '0;
        end else begin
          base[i][j] = matrix[i][j];
        end
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_row
    rmc_row_rotate #(
      .FRACTION_BITS (FRACTION_BITS)
    ) u_row (
      .axis    (b_axis),
      .cos_val (cos_val),
      .sin_val (sin_val),
      .row_in  (base[i]),
      .row_out (matrix_next[i])
    );
  end

  // Running matrix, which is also the output word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          matrix[i][j] <= (i == j) ? One : '0;
        end
      end
    end else if (out_en) begin
      out_valid <= b_valid;
      if (b_valid) begin
        matrix <= matrix_next;
      end
    end
  end

  assign m00 = matrix[0][0];
  assign m01 = matrix[0][1];
  assign m02 = matrix[0][2];
  assign m10 = matrix[1][0];
  assign m11 = matrix[1][1];
  assign m12 = matrix[1][2];
  assign m20 = matrix[2][0];
  assign m21 = matrix[2][1];
  assign m22 = matrix[2][2];

  // Reset empties both stages
  a_reset_empty: assert property (@(posedge clk) rst |=> (!out_valid && !b_valid))
    else $error("pipeline not empty after reset");

  // An accepted word is in the ROM stage on the next cycle
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> b_valid)
    else $error("accepted word lost in ROM stage");

  // A word in the ROM stage with a free output moves to the output
  a_stage_moves: assert property (@(posedge clk) disable iff (rst)
    (b_valid && !(out_valid && out_stall)) |=> out_valid)
    else $error("ROM stage word did not reach output");

  // Restart with no rotation yields the identity
  a_restart_identity: assert property (@(posedge clk) disable iff (rst)
    (b_valid && out_en && b_restart && (b_axis == rmc_pkg::AXIS_NONE)) |=>
    (m00 == One && m11 == One && m22 == One && m01 == '0 && m02 == '0 &&
     m10 == '0 && m12 == '0 && m20 == '0 && m21 == '0))
    else $error("restart without rotation did not give identity");

endmodule
